>>> rtl/tracked_body_zone_event_detector_defines.svh
// Assertion helpers for the checker file, tbzed_checker.
`ifndef TRACKED_BODY_ZONE_EVENT_DETECTOR_DEFINES_SVH
`define TRACKED_BODY_ZONE_EVENT_DETECTOR_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define TBZED_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tbzed: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define TBZED_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tbzed: next-cycle check failed");

`endif

>>> rtl/tbzed_pkg.sv
package tbzed_pkg;

  localparam int DEF_MAX_BODIES = 8;
  localparam int DEF_FRAC_BITS  = 12;

  localparam int IN_W       = 152;
  localparam int OUT_W      = 32;
  localparam int KIND_W     = 4;
  localparam int VAL_W      = 24;
  localparam int SLOT_FLD_W = 6;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_EVENT_MODE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_TRACK = 8'd1;

  localparam logic [KIND_W-1:0] KIND_START_EV   = 4'd0;
  localparam logic [KIND_W-1:0] KIND_START_DIST = 4'd1;
  localparam logic [KIND_W-1:0] KIND_LEVEL      = 4'd2;
  localparam logic [KIND_W-1:0] KIND_PLANE_NEG  = 4'd3;
  localparam logic [KIND_W-1:0] KIND_PLANE_POS  = 4'd4;
  localparam logic [KIND_W-1:0] KIND_SPHERE_NEG = 4'd5;
  localparam logic [KIND_W-1:0] KIND_SPHERE_POS = 4'd6;
  localparam logic [KIND_W-1:0] KIND_DONE       = 4'd7;
  localparam logic [KIND_W-1:0] KIND_FULL       = 4'd8;

  typedef enum logic [2:0] {
    SEL_START,
    SEL_FULL,
    SEL_LEVEL,
    SEL_PLANE,
    SEL_SPHERE,
    SEL_DONE
  } res_sel_e;

  typedef struct packed {
    logic     load;
    logic     rd;
    logic     hit;
    logic     inc;
    logic     insert;
    logic     set_started;
    logic     emit;
    res_sel_e sel;
    logic     div_start;
    logic     commit;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic match;
    logic last_idx;
    logic full;
    logic started;
    logic event_mode;
    logic found;
    logic plane_chg;
    logic sph_chg;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/tracked_body_zone_event_detector.sv
// Tracked body zone event detector.
// Input stream s_axis: one word per tracked body; s_axis_tlast marks the last
// body of a frame. Output stream m_axis: one or more result words per body,
// m_axis_tlast set on the closing done word. m_axis_tuser carries the kind.
// Config channel cfg_*: index 0 event_mode (reset 1), index 1 start_track
// (reset 0); always ready, write it only while no body is in flight.
// One body at a time. The id search reads the table memory one entry at a
// time, a read state and then a compare state per entry, until a known body
// is found or every entry has been read for a new one. Event mode then gives
// a plane word and a sphere word where a zone flag changed, after any start
// or table-full word; distance mode runs the bit-serial level divider, then
// gives the level word. Both modes close with the done word.
// s_axis_tready is high only between bodies.
// Reset empties the body table, clears the started and frame red flags and
// loads the register defaults; no clearing pass is needed.
// Results sit in a single output register: a stalled m_axis_tready holds it
// and the sequencer waits; the next body is taken while the done word waits.
module tracked_body_zone_event_detector #(
  parameter int MAX_BODIES = tbzed_pkg::DEF_MAX_BODIES,
  parameter int FRAC_BITS  = tbzed_pkg::DEF_FRAC_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // body_id[31:0], left_plane_dist[55:32], right_plane_dist[79:56],
  // left_sphere_dist[103:80], right_sphere_dist[127:104], body_size[150:128]
  input  logic [tbzed_pkg::IN_W-1:0]       s_axis_tdata,
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // body_slot[5:0], value[29:6], frame_red[30]
  output logic [tbzed_pkg::OUT_W-1:0]      m_axis_tdata,
  // event_kind[3:0]
  output logic [tbzed_pkg::KIND_W-1:0]     m_axis_tuser,
  output logic                             m_axis_tlast,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tbzed_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tbzed_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  tbzed_pkg::cmd_t cmd;
  tbzed_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  tbzed_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  tbzed_dp #(
    .MAX_BODIES(MAX_BODIES),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_data_o (m_axis_tdata),
    .out_user_o (m_axis_tuser),
    .out_last_o (m_axis_tlast)
  );

endmodule

>>> rtl/tbzed_div.sv
module tbzed_div #(
  parameter int NW = 37
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [22:0]   den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o,
  output logic          rem_nz_o
);

  localparam int CW = $clog2(NW);

  logic [NW-1:0] num_q, num_d;
  logic [22:0]   rem_q, rem_d;
  logic [22:0]   den_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [23:0]   trial;
  logic          ge;

  // Restoring step: one quotient bit per cycle, MSB first.
  always_comb begin
    trial = {rem_q, num_q[NW-1]};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? 23'(trial - {1'b0, den_q}) : trial[22:0];
    num_d = {num_q[NW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign done_o   = done_q;
  assign quo_o    = num_q;
  assign rem_nz_o = rem_q != '0;

endmodule

>>> rtl/tbzed_dp.sv
module tbzed_dp #(
  parameter int MAX_BODIES = tbzed_pkg::DEF_MAX_BODIES,
  parameter int FRAC_BITS  = tbzed_pkg::DEF_FRAC_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tbzed_pkg::cmd_t                  cmd_i,
  output tbzed_pkg::sts_t                  sts_o,
  input  logic [tbzed_pkg::IN_W-1:0]       in_data_i,
  input  logic                             in_last_i,
  input  logic                             cfg_valid_i,
  input  logic [tbzed_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tbzed_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [tbzed_pkg::OUT_W-1:0]      out_data_o,
  output logic [tbzed_pkg::KIND_W-1:0]     out_user_o,
  output logic                             out_last_o
);

  localparam int SLOT_W = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
  localparam int CNT_W  = $clog2(MAX_BODIES + 1);
  localparam int NW     = 25 + FRAC_BITS;

  localparam logic [23:0] LVL_ONE = 24'(2 ** FRAC_BITS);
  localparam logic [23:0] LVL_MIN = 24'h800000;
  localparam logic [23:0] LVL_MAX = 24'h7FFFFF;
  localparam logic [NW:0] NEG_LIM = (NW + 1)'(8388608);
  localparam logic [NW:0] POS_LIM = (NW + 1)'(8388607);

  function automatic logic [23:0] min_s(input logic [23:0] a, input logic [23:0] b);
    return ($signed(a) < $signed(b)) ? a : b;
  endfunction

  // item word
  logic [31:0]       id_q;
  logic [22:0]       size_q;
  logic              fend_q;
  logic [23:0]       m_q, pmin_q, smin_q;
  logic [23:0]       lp, rp, ls, rs, pmin_in, smin_in;

  // body table
  logic [31:0]       id_mem [MAX_BODIES];
  logic [31:0]       rd_q;
  logic [CNT_W-1:0]  cnt_q, idx_q;
  logic [SLOT_W-1:0] slot_q;
  logic              found_q;
  logic [MAX_BODIES-1:0] under_q, insph_q;

  logic              started_q, acc_q;
  logic              event_mode_q;
  logic [7:0]        start_track_q;

  // level divider
  logic [25:0]       diff, diff_abs;
  logic              diff_neg;
  logic              div_done, rem_nz;
  logic [NW-1:0]     quo;
  logic [NW:0]       qx;
  logic [23:0]       level;

  // result word
  logic              out_valid_q;
  logic [3:0]        kind_q, kind_d;
  logic [5:0]        oslot_q, oslot_d;
  logic [23:0]       val_q, val_d;
  logic              red_q, red_d, last_q, last_d;

  assign lp = in_data_i[55:32];
  assign rp = in_data_i[79:56];
  assign ls = in_data_i[103:80];
  assign rs = in_data_i[127:104];
  assign pmin_in = min_s(lp, rp);
  assign smin_in = min_s(ls, rs);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q   <= in_data_i[31:0];
      size_q <= in_data_i[150:128];
      fend_q <= in_last_i;
      pmin_q <= pmin_in;
      smin_q <= smin_in;
      m_q    <= min_s(pmin_in, smin_in);
    end
    if (cmd_i.insert) begin
      id_mem[cnt_q[SLOT_W-1:0]] <= id_q;
    end
    if (cmd_i.rd) begin
      rd_q <= id_mem[idx_q[SLOT_W-1:0]];
    end
    if (cmd_i.hit) begin
      slot_q <= idx_q[SLOT_W-1:0];
    end
    if (cmd_i.insert) begin
      slot_q <= cnt_q[SLOT_W-1:0];
      under_q[cnt_q[SLOT_W-1:0]] <= 1'b0;
      insph_q[cnt_q[SLOT_W-1:0]] <= 1'b0;
    end
    // zone flags move only in event mode, for bodies held in the table
    if (cmd_i.commit && event_mode_q && found_q) begin
      under_q[slot_q] <= pmin_q[23];
      insph_q[slot_q] <= smin_q[23];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q         <= '0;
      idx_q         <= '0;
      found_q       <= 1'b0;
      started_q     <= 1'b0;
      acc_q         <= 1'b0;
      event_mode_q  <= 1'b1;
      start_track_q <= '0;
    end else begin
      if (cmd_i.load) begin
        idx_q   <= '0;
        found_q <= 1'b0;
      end
      if (cmd_i.inc) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      if (cmd_i.hit) begin
        found_q <= 1'b1;
      end
      if (cmd_i.insert) begin
        cnt_q   <= cnt_q + CNT_W'(1);
        found_q <= 1'b1;
      end
      if (cmd_i.set_started) begin
        started_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        acc_q <= fend_q ? 1'b0 : (acc_q | m_q[23]);
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          tbzed_pkg::REG_EVENT_MODE:  event_mode_q  <= cfg_data_i[0];
          tbzed_pkg::REG_START_TRACK: start_track_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // size - 2*m, then floor division of its magnitude by size
  assign diff     = {3'b000, size_q} - {m_q[23], m_q, 1'b0};
  assign diff_neg = diff[25];
  assign diff_abs = diff_neg ? (26'd0 - diff) : diff;

  tbzed_div #(
    .NW(NW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (NW'(diff_abs[24:0]) << FRAC_BITS),
    .den_i   (size_q),
    .done_o  (div_done),
    .quo_o   (quo),
    .rem_nz_o(rem_nz)
  );

  assign qx = {1'b0, quo} + (NW + 1)'(rem_nz);

  always_comb begin
    if (m_q[23]) begin
      level = LVL_ONE;
    end else if (size_q == '0) begin
      level = LVL_MIN;
    end else if (diff_neg) begin
      level = (qx > NEG_LIM) ? LVL_MIN : (24'd0 - qx[23:0]);
    end else begin
      level = ({1'b0, quo} > POS_LIM) ? LVL_MAX : quo[23:0];
    end
  end

  always_comb begin
    oslot_d = 6'(slot_q);
    val_d   = '0;
    red_d   = 1'b0;
    last_d  = 1'b0;
    unique case (cmd_i.sel)
      tbzed_pkg::SEL_START: begin
        kind_d = event_mode_q ? tbzed_pkg::KIND_START_EV : tbzed_pkg::KIND_START_DIST;
        val_d  = 24'(start_track_q);
      end
      tbzed_pkg::SEL_FULL: begin
        kind_d  = tbzed_pkg::KIND_FULL;
        oslot_d = '0;
      end
      tbzed_pkg::SEL_LEVEL: begin
        kind_d  = tbzed_pkg::KIND_LEVEL;
        oslot_d = '0;
        val_d   = level;
      end
      tbzed_pkg::SEL_PLANE: begin
        kind_d = pmin_q[23] ? tbzed_pkg::KIND_PLANE_NEG : tbzed_pkg::KIND_PLANE_POS;
        val_d  = pmin_q;
      end
      tbzed_pkg::SEL_SPHERE: begin
        kind_d = smin_q[23] ? tbzed_pkg::KIND_SPHERE_NEG : tbzed_pkg::KIND_SPHERE_POS;
        val_d  = smin_q;
      end
      default: begin
        kind_d  = tbzed_pkg::KIND_DONE;
        oslot_d = '0;
        red_d   = acc_q | m_q[23];
        last_d  = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_q  <= kind_d;
      oslot_q <= oslot_d;
      val_q   <= val_d;
      red_q   <= red_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {1'b0, red_q, val_q, oslot_q};
  assign out_user_o  = kind_q;
  assign out_last_o  = last_q;

  assign sts_o.cnt_zero   = cnt_q == '0;
  assign sts_o.match      = rd_q == id_q;
  assign sts_o.last_idx   = (idx_q + CNT_W'(1)) == cnt_q;
  assign sts_o.full       = cnt_q == CNT_W'(MAX_BODIES);
  assign sts_o.started    = started_q;
  assign sts_o.event_mode = event_mode_q;
  assign sts_o.found      = found_q;
  assign sts_o.plane_chg  = pmin_q[23] != under_q[slot_q];
  assign sts_o.sph_chg    = smin_q[23] != insph_q[slot_q];
  assign sts_o.div_done   = div_done;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule

>>> rtl/tbzed_ctrl.sv
module tbzed_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tbzed_pkg::sts_t sts_i,
  output tbzed_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRD,
    ST_SCMP,
    ST_INS,
    ST_START,
    ST_FULL,
    ST_EVP,
    ST_EVS,
    ST_DGO,
    ST_DWAIT,
    ST_LEVEL,
    ST_DONE
  } state_e;

  state_e state_q, state_d, mode_st;

  assign in_ready_o = state_q == ST_IDLE;
  assign mode_st    = sts_i.event_mode ? ST_EVP : ST_DGO;

  always_comb begin
    cmd_o   = '0;
    cmd_o.sel = tbzed_pkg::SEL_DONE;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.cnt_zero ? ST_INS : ST_SRD;
        end
      end
      ST_SRD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_SCMP;
      end
      ST_SCMP: begin
        if (sts_i.match) begin
          cmd_o.hit = 1'b1;
          state_d   = mode_st;
        end else if (sts_i.last_idx) begin
          state_d = ST_INS;
        end else begin
          cmd_o.inc = 1'b1;
          state_d   = ST_SRD;
        end
      end
      ST_INS: begin
        if (sts_i.full) begin
          state_d = ST_FULL;
        end else begin
          cmd_o.insert = 1'b1;
          state_d      = sts_i.started ? mode_st : ST_START;
        end
      end
      ST_START: begin
        if (sts_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.sel         = tbzed_pkg::SEL_START;
          cmd_o.set_started = 1'b1;
          state_d           = mode_st;
        end
      end
      ST_FULL: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = tbzed_pkg::SEL_FULL;
          state_d    = mode_st;
        end
      end
      ST_EVP: begin
        // skip when the body has no slot or its plane flag held
        if (!(sts_i.found && sts_i.plane_chg)) begin
          state_d = ST_EVS;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = tbzed_pkg::SEL_PLANE;
          state_d    = ST_EVS;
        end
      end
      ST_EVS: begin
        if (!(sts_i.found && sts_i.sph_chg)) begin
          state_d = ST_DONE;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = tbzed_pkg::SEL_SPHERE;
          state_d    = ST_DONE;
        end
      end
      ST_DGO: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_LEVEL;
        end
      end
      ST_LEVEL: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = tbzed_pkg::SEL_LEVEL;
          state_d    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.sel    = tbzed_pkg::SEL_DONE;
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/tbzed_checker.sv
`include "tracked_body_zone_event_detector_defines.svh"

module tbzed_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [tbzed_pkg::OUT_W-1:0]  m_axis_tdata,
  input logic [tbzed_pkg::KIND_W-1:0] m_axis_tuser,
  input logic                         m_axis_tlast
);

  // hold a stalled result word
  `TBZED_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

  // one body in flight: the input closes right after a take
  `TBZED_ASSERT_NEXT(a_in_single, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // last marks exactly the done word
  `TBZED_ASSERT_SAME(a_last_done, m_axis_tvalid, m_axis_tlast == (m_axis_tuser == tbzed_pkg::KIND_DONE))

  // red flag only on done words, slot zero on level and table-full words
  `TBZED_ASSERT_SAME(a_red_slot, m_axis_tvalid && !m_axis_tlast, !m_axis_tdata[30] && ((m_axis_tuser != tbzed_pkg::KIND_LEVEL && m_axis_tuser != tbzed_pkg::KIND_FULL) || m_axis_tdata[5:0] == 6'd0))

endmodule

bind tracked_body_zone_event_detector tbzed_checker u_checker (.*);
